// ===== design/uwrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uwrc_pkg
// Shared types, constants and character classification functions for the
// UTF-8 word and repeated-consonant counter.
// ----------------------------------------------------------------------------
package uwrc_pkg;

    // Default width of the word and repeat counters.
    localparam int COUNT_BITS_DEFAULT = 32;
    localparam int OUT_BITS           = 32;
    localparam int LETTER_COUNT       = 26;

    // Letter indexes (a = 0 ... z = 25) used for folded letters.
    localparam logic [4:0] LTR_A = 5'd0;
    localparam logic [4:0] LTR_C = 5'd2;
    localparam logic [4:0] LTR_E = 5'd4;
    localparam logic [4:0] LTR_I = 5'd8;
    localparam logic [4:0] LTR_O = 5'd14;
    localparam logic [4:0] LTR_U = 5'd20;

    // Class of a complete character.
    typedef enum logic [1:0] {
        CLS_IGNORE,
        CLS_END,
        CLS_CHAR
    } t_cls;

    // Classification of one complete character.
    typedef struct packed {
        t_cls       cls;
        logic       is_letter;
        logic [4:0] letter;
    } t_class;

    // Event handed from the decoder to the word logic for one request.
    typedef struct packed {
        logic   stray;
        t_class chr;
    } t_char_ev;

    // Classify a single-byte (ASCII) character.
    function automatic t_class ascii_classify(input logic [6:0] c);
        t_class r;
        r = '{cls: CLS_IGNORE, is_letter: 1'b0, letter: 5'd0};
        case (c) inside
            7'h20, 7'h09, 7'h0A, 7'h0D, 7'h2D, 7'h22, 7'h5B, 7'h5D,
            7'h2E, 7'h2C, 7'h3A, 7'h3B, 7'h3F, 7'h21: begin
                r.cls = CLS_END;
            end
            [7'h41:7'h5A], [7'h61:7'h7A]: begin
                // Upper and lower case share the low five bits.
                r.cls       = CLS_CHAR;
                r.is_letter = 1'b1;
                r.letter    = c[4:0] - 5'd1;
            end
            [7'h30:7'h39], 7'h5F: begin
                r.cls = CLS_CHAR;
            end
            default: begin
                r.cls = CLS_IGNORE;
            end
        endcase
        return r;
    endfunction

    // Classify a two-byte character whose lead byte is C3.
    function automatic t_class c3_classify(input logic [7:0] lo);
        t_class r;
        r = '{cls: CLS_CHAR, is_letter: 1'b1, letter: LTR_A};
        case (lo) inside
            8'hA1, 8'hA0, 8'hA2, 8'hA3, 8'h81, 8'h80, 8'h82, 8'h83: r.letter = LTR_A;
            8'hA9, 8'hA8, 8'hAA, 8'h89, 8'h88, 8'h8A:               r.letter = LTR_E;
            8'hAD, 8'hAC, 8'h8D, 8'h8C:                             r.letter = LTR_I;
            8'hB3, 8'hB2, 8'hB4, 8'hB5, 8'h93, 8'h92, 8'h94, 8'h95: r.letter = LTR_O;
            8'hBA, 8'hB9, 8'h9A, 8'h99:                             r.letter = LTR_U;
            8'hA7, 8'h87:                                           r.letter = LTR_C;
            default: begin
                r.cls       = CLS_IGNORE;
                r.is_letter = 1'b0;
            end
        endcase
        return r;
    endfunction

    // Classify a three-byte character E2 80 xx by its last byte.
    function automatic t_class e280_classify(input logic [7:0] lo);
        t_class r;
        r = '{cls: CLS_IGNORE, is_letter: 1'b0, letter: 5'd0};
        case (lo) inside
            8'h9C, 8'h9D, 8'h93, 8'hA6: r.cls = CLS_END;
            default:                    r.cls = CLS_IGNORE;
        endcase
        return r;
    endfunction

endpackage

// ===== design/uwrc_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uwrc_decode
// UTF-8 byte decoder. Tracks the continuation bytes still expected and the
// kind of the open sequence, and emits one classified character event.
// ----------------------------------------------------------------------------
module uwrc_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output uwrc_pkg::t_char_ev  o_ev
);

    // Only sequences that can map to a counted class are remembered.
    typedef enum logic [1:0] {
        KIND_OTHER,
        KIND_C3,
        KIND_E2
    } t_kind;

    localparam logic [7:0] LEAD_C3 = 8'hC3;
    localparam logic [7:0] LEAD_E2 = 8'hE2;
    localparam logic [7:0] MID_80  = 8'h80;

    logic [1:0] r_pending;
    logic [1:0] n_pending;
    t_kind      r_kind;
    t_kind      n_kind;

    always_comb begin
        n_pending     = r_pending;
        n_kind        = r_kind;
        o_ev.stray    = 1'b0;
        o_ev.chr      = '{cls: uwrc_pkg::CLS_IGNORE, is_letter: 1'b0, letter: 5'd0};
        if (r_pending != 2'd0) begin
            if (i_byte[7:6] == 2'b10) begin
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd2 && r_kind == KIND_E2 && i_byte != MID_80) begin
                    n_kind = KIND_OTHER;
                end
                if (r_pending == 2'd1) begin
                    unique case (r_kind)
                        KIND_C3:  o_ev.chr = uwrc_pkg::c3_classify(i_byte);
                        KIND_E2:  o_ev.chr = uwrc_pkg::e280_classify(i_byte);
                        default:  o_ev.chr.cls = uwrc_pkg::CLS_IGNORE;
                    endcase
                end
            end else begin
                // A sequence cut short drops both the partial character and this byte.
                n_pending = 2'd0;
            end
        end else if (i_byte >= 8'hF0) begin
            n_pending = 2'd3;
            n_kind    = KIND_OTHER;
        end else if (i_byte >= 8'hE0) begin
            n_pending = 2'd2;
            n_kind    = (i_byte == LEAD_E2) ? KIND_E2 : KIND_OTHER;
        end else if (i_byte >= 8'hC0) begin
            n_pending = 2'd1;
            n_kind    = (i_byte == LEAD_C3) ? KIND_C3 : KIND_OTHER;
        end else if (i_byte >= 8'h80) begin
            o_ev.stray = 1'b1;
        end else begin
            o_ev.chr = uwrc_pkg::ascii_classify(i_byte[6:0]);
        end
        if (i_last || o_ev.stray) begin
            n_pending = 2'd0;
            n_kind    = KIND_OTHER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_kind    <= KIND_OTHER;
        end else if (i_fire) begin
            r_pending <= n_pending;
            r_kind    <= n_kind;
        end
    end

endmodule

// ===== design/utf8_word_and_repeat_consonant_counter_top.sv =====
`timescale 1ns / 1ps
// Results are registered; a final or stray byte first waits for a free result slot.
// Throughput: one byte per cycle; the decoder and the word counters handle a byte in
// one pass, so intake stalls only while a result waits and the registered byte would
// produce another one.
// Reset: synchronous, active low; clears decoder, word state, counts and valids.
// Bytes that cause no result produce nothing on the output channel.
// ----------------------------------------------------------------------------
// utf8_word_and_repeat_consonant_counter_top
// Counts words, and words with a repeated consonant, in a UTF-8 byte stream.
// ----------------------------------------------------------------------------
module utf8_word_and_repeat_consonant_counter_top #(
    parameter int COUNT_BITS = uwrc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte request channel.
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_text,
    // Result request channel.
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_total_words,
    output logic [31:0] o_repeat_words,
    output logic        o_bad_encoding
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Input register. A byte that produces no result moves on at once; a byte
    // that ends the text moves on only when the result slot is free.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       out_free;
    logic       s1_fire;

    assign out_free = !o_valid || i_ready;
    assign o_ready  = !r_in_valid || s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_end_of_text;
        end
    end

    // UTF-8 decoding and character classification.
    uwrc_pkg::t_char_ev ev;

    uwrc_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_ev    (ev)
    );

    // Word state and counters.
    logic                                r_in_word;
    logic [uwrc_pkg::LETTER_COUNT-1:0]   r_seen;
    logic                                r_has_rep;
    logic [COUNT_BITS-1:0]               r_word_total;
    logic [COUNT_BITS-1:0]               r_rep_total;

    logic                                n_in_word;
    logic [uwrc_pkg::LETTER_COUNT-1:0]   n_seen;
    logic                                n_has_rep;
    logic [COUNT_BITS-1:0]               n_word_total;
    logic [COUNT_BITS-1:0]               n_rep_total;
    logic [COUNT_BITS-1:0]               fin_word_total;
    logic [COUNT_BITS-1:0]               fin_rep_total;
    logic                                is_cons;
    logic [31:0]                         fin_word_out;
    logic [31:0]                         fin_rep_out;

    // A consonant is any folded letter other than the five vowels.
    assign is_cons = ev.chr.is_letter &&
                     ev.chr.letter != uwrc_pkg::LTR_A && ev.chr.letter != uwrc_pkg::LTR_E &&
                     ev.chr.letter != uwrc_pkg::LTR_I && ev.chr.letter != uwrc_pkg::LTR_O &&
                     ev.chr.letter != uwrc_pkg::LTR_U;

    always_comb begin
        n_in_word    = r_in_word;
        n_seen       = r_seen;
        n_has_rep    = r_has_rep;
        n_word_total = r_word_total;
        n_rep_total  = r_rep_total;
        case (ev.chr.cls)
            uwrc_pkg::CLS_END: begin
                // A separator closes the open word, if any.
                if (r_in_word) begin
                    if (r_word_total != CNT_MAX) begin
                        n_word_total = r_word_total + 1'b1;
                    end
                    if (r_has_rep && r_rep_total != CNT_MAX) begin
                        n_rep_total = r_rep_total + 1'b1;
                    end
                end
                n_in_word = 1'b0;
                n_seen    = '0;
                n_has_rep = 1'b0;
            end
            uwrc_pkg::CLS_CHAR: begin
                n_in_word = 1'b1;
                if (is_cons) begin
                    if (r_seen[ev.chr.letter]) begin
                        n_has_rep = 1'b1;
                    end
                    n_seen[ev.chr.letter] = 1'b1;
                end
            end
            default: begin
                n_in_word = r_in_word;
            end
        endcase

        // On the final byte a word without a trailing separator still counts.
        fin_word_total = n_word_total;
        fin_rep_total  = n_rep_total;
        if (n_in_word) begin
            if (n_word_total != CNT_MAX) begin
                fin_word_total = n_word_total + 1'b1;
            end
            if (n_has_rep && n_rep_total != CNT_MAX) begin
                fin_rep_total = n_rep_total + 1'b1;
            end
        end
    end

    // The result fields show each count saturated to 32 bits.
    generate
        if (COUNT_BITS > uwrc_pkg::OUT_BITS) begin : g_wide
            always_comb begin
                fin_word_out = (|fin_word_total[COUNT_BITS-1:uwrc_pkg::OUT_BITS]) ?
                               '1 : fin_word_total[uwrc_pkg::OUT_BITS-1:0];
                fin_rep_out  = (|fin_rep_total[COUNT_BITS-1:uwrc_pkg::OUT_BITS]) ?
                               '1 : fin_rep_total[uwrc_pkg::OUT_BITS-1:0];
            end
        end else begin : g_narrow
            assign fin_word_out = 32'(fin_word_total);
            assign fin_rep_out  = 32'(fin_rep_total);
        end
    endgenerate

    // Either a stray continuation byte or the final byte ends the text and
    // clears every piece of word state for the next text.
    logic text_done;
    assign text_done = ev.stray || r_in_last;

    // Only a byte that produces a result has to wait for the result slot.
    assign s1_fire = r_in_valid && (out_free || !text_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_word    <= 1'b0;
            r_seen       <= '0;
            r_has_rep    <= 1'b0;
            r_word_total <= '0;
            r_rep_total  <= '0;
        end else if (s1_fire) begin
            if (text_done) begin
                r_in_word    <= 1'b0;
                r_seen       <= '0;
                r_has_rep    <= 1'b0;
                r_word_total <= '0;
                r_rep_total  <= '0;
            end else begin
                r_in_word    <= n_in_word;
                r_seen       <= n_seen;
                r_has_rep    <= n_has_rep;
                r_word_total <= n_word_total;
                r_rep_total  <= n_rep_total;
            end
        end
    end

    // Result register. A stray continuation byte reports zero counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (s1_fire && text_done) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && text_done) begin
            o_bad_encoding <= ev.stray;
            o_total_words  <= ev.stray ? 32'd0 : fin_word_out;
            o_repeat_words <= ev.stray ? 32'd0 : fin_rep_out;
        end
    end

endmodule

// ===== bench/tb_utf8_word_and_repeat_consonant_counter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_word_and_repeat_consonant_counter_top
// Self-checking bench for the UTF-8 word and repeated-consonant counter. It
// sends short texts, one request per byte, with random idling on both
// channels. It predicts each result and compares it with the block's output.
// ----------------------------------------------------------------------------
module tb_utf8_word_and_repeat_consonant_counter_top;

    localparam int CNT_W          = uwrc_pkg::COUNT_BITS_DEFAULT;
    localparam int RANDOM_BYTES   = 280;
    localparam int PRESSURE_TEXTS = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int IDLE_LIMIT     = 4000;
    localparam int DRAIN_CYCLES   = 10;

    // One result request as the block should present it.
    typedef struct packed {
        logic [31:0] words;
        logic [31:0] repeats;
        logic        bad;
    } t_count_result;

    // Tracks the decoder and word state of the block. For every accepted byte
    // it works out the result, if any, and checks returned results in order.
    class t_word_count_scoreboard;
        logic [1:0]       bytes_waiting;
        logic [31:0]      char_code;
        logic             in_word;
        logic [25:0]      seen;
        logic             has_repeat;
        logic [CNT_W-1:0] word_cnt;
        logic [CNT_W-1:0] repeat_cnt;
        t_count_result    expected_q[$];
        int               errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            bytes_waiting = '0;
            char_code     = '0;
            in_word       = 1'b0;
            seen          = '0;
            has_repeat    = 1'b0;
            word_cnt      = '0;
            repeat_cnt    = '0;
        endfunction

        function void close_word();
            if (in_word) begin
                if (word_cnt != '1) word_cnt++;
                if (has_repeat && repeat_cnt != '1) repeat_cnt++;
            end
            in_word    = 1'b0;
            seen       = '0;
            has_repeat = 1'b0;
        endfunction

        function logic [31:0] to_out(input logic [CNT_W-1:0] cnt);
            logic [63:0] wide;
            wide = 64'(cnt);
            return (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
        endfunction

        // Classify one complete character and update the word state.
        function void take_char(input logic [31:0] code);
            logic [7:0]     lo;
            logic           letter_ok;
            logic [4:0]     idx;
            uwrc_pkg::t_cls cls;
            lo        = code[7:0];
            letter_ok = 1'b0;
            idx       = 5'd0;
            cls       = uwrc_pkg::CLS_IGNORE;
            if (code < 32'h80) begin
                case (lo) inside
                    8'h20, 8'h09, 8'h0A, 8'h0D, 8'h2D, 8'h22, 8'h5B, 8'h5D,
                    8'h2E, 8'h2C, 8'h3A, 8'h3B, 8'h3F, 8'h21: begin
                        cls = uwrc_pkg::CLS_END;
                    end
                    default: begin
                        if (lo >= 8'h41 && lo <= 8'h5A) begin
                            cls       = uwrc_pkg::CLS_CHAR;
                            letter_ok = 1'b1;
                            idx       = 5'(lo - 8'h41);
                        end else if (lo >= 8'h61 && lo <= 8'h7A) begin
                            cls       = uwrc_pkg::CLS_CHAR;
                            letter_ok = 1'b1;
                            idx       = 5'(lo - 8'h61);
                        end else if ((lo >= 8'h30 && lo <= 8'h39) || lo == 8'h5F) begin
                            cls = uwrc_pkg::CLS_CHAR;
                        end
                    end
                endcase
            end else if (code[31:8] == 24'h0000C3) begin
                cls       = uwrc_pkg::CLS_CHAR;
                letter_ok = 1'b1;
                case (lo) inside
                    8'hA1, 8'hA0, 8'hA2, 8'hA3, 8'h81, 8'h80, 8'h82, 8'h83:
                        idx = uwrc_pkg::LTR_A;
                    8'hA9, 8'hA8, 8'hAA, 8'h89, 8'h88, 8'h8A:
                        idx = uwrc_pkg::LTR_E;
                    8'hAD, 8'hAC, 8'h8D, 8'h8C:
                        idx = uwrc_pkg::LTR_I;
                    8'hB3, 8'hB2, 8'hB4, 8'hB5, 8'h93, 8'h92, 8'h94, 8'h95:
                        idx = uwrc_pkg::LTR_O;
                    8'hBA, 8'hB9, 8'h9A, 8'h99:
                        idx = uwrc_pkg::LTR_U;
                    8'hA7, 8'h87:
                        idx = uwrc_pkg::LTR_C;
                    default: begin
                        cls       = uwrc_pkg::CLS_IGNORE;
                        letter_ok = 1'b0;
                    end
                endcase
            end else if (code == 32'h00E2809C || code == 32'h00E2809D ||
                         code == 32'h00E28093 || code == 32'h00E280A6) begin
                cls = uwrc_pkg::CLS_END;
            end

            if (cls == uwrc_pkg::CLS_END) begin
                close_word();
            end else if (cls == uwrc_pkg::CLS_CHAR) begin
                in_word = 1'b1;
                if (letter_ok && idx != uwrc_pkg::LTR_A && idx != uwrc_pkg::LTR_E &&
                    idx != uwrc_pkg::LTR_I && idx != uwrc_pkg::LTR_O &&
                    idx != uwrc_pkg::LTR_U) begin
                    if (seen[idx]) has_repeat = 1'b1;
                    seen[idx] = 1'b1;
                end
            end
        endfunction

        function void note_byte(input logic [7:0] b, input logic last);
            if (bytes_waiting != 2'd0) begin
                if (b[7:6] == 2'b10) begin
                    char_code = {char_code[23:0], b};
                    bytes_waiting--;
                    if (bytes_waiting == 2'd0) take_char(char_code);
                end else begin
                    // A new lead or ASCII byte cuts the sequence short.
                    bytes_waiting = 2'd0;
                    char_code     = '0;
                end
            end else if (b >= 8'hF0) begin
                char_code     = {24'd0, b};
                bytes_waiting = 2'd3;
            end else if (b >= 8'hE0) begin
                char_code     = {24'd0, b};
                bytes_waiting = 2'd2;
            end else if (b >= 8'hC0) begin
                char_code     = {24'd0, b};
                bytes_waiting = 2'd1;
            end else if (b >= 8'h80) begin
                // A stray continuation byte reports an error and wipes all state.
                clear_state();
                expected_q.push_back('{words: 32'd0, repeats: 32'd0, bad: 1'b1});
                return;
            end else begin
                char_code = {24'd0, b};
                take_char(char_code);
            end

            if (!last) return;
            close_word();
            expected_q.push_back('{words: to_out(word_cnt), repeats: to_out(repeat_cnt),
                                   bad: 1'b0});
            clear_state();
        endfunction

        function void check_result(input logic [31:0] words, input logic [31:0] repeats,
                                   input logic bad);
            t_count_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result words=%0d repeats=%0d bad=%0b",
                         $time, words, repeats, bad);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (words !== want.words) begin
                $display("%0t: total_words expected %0d, actual %0d",
                         $time, want.words, words);
                errors++;
            end
            if (repeats !== want.repeats) begin
                $display("%0t: repeat_words expected %0d, actual %0d",
                         $time, want.repeats, repeats);
                errors++;
            end
            if (bad !== want.bad) begin
                $display("%0t: bad_encoding expected %0b, actual %0b",
                         $time, want.bad, bad);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_end_of_text;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_total_words;
    logic [31:0] o_repeat_words;
    logic        o_bad_encoding;

    t_word_count_scoreboard sb = new();

    // The text being built and sent next; the last byte carries end_of_text.
    logic [7:0] text_q[$];
    // When set, the sender offers bytes back to back with no gaps.
    bit         no_gaps;
    // Set by the stimulus to make the receiver hold off for a long stretch.
    bit         hold_req;

    utf8_word_and_repeat_consonant_counter_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_end_of_text  (i_end_of_text),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_total_words  (o_total_words),
        .o_repeat_words (o_repeat_words),
        .o_bad_encoding (o_bad_encoding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offer one byte request and wait for the block to take it. The task is
    // entered and left at a falling edge, so payload changes never meet the
    // sampling edge. Valid stays high between back-to-back requests.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_data_byte   <= b;
        i_end_of_text <= last;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_text();
        for (int k = 0; k < text_q.size(); k++) begin
            send_byte(text_q[k], k == text_q.size() - 1);
        end
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'(8'h80 + $urandom_range(0, 63));
    endfunction

    // Append one word-building piece: mostly letters, with every other kind
    // of character mixed in, including broken encodings now and then.
    task automatic add_word_piece();
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            // A small consonant set makes repeats common.
            case ($urandom_range(0, 5))
                0: c = 8'h62;
                1: c = 8'h63;
                2: c = 8'h64;
                3: c = 8'h6E;
                4: c = 8'h73;
                default: c = 8'h74;
            endcase
            if ($urandom_range(0, 2) == 0) c = c - 8'h20;
            text_q.push_back(c);
        end else if (r < 55) begin
            c = 8'(8'h61 + $urandom_range(0, 25));
            if ($urandom_range(0, 3) == 0) c = c - 8'h20;
            text_q.push_back(c);
        end else if (r < 62) begin
            text_q.push_back($urandom_range(0, 4) == 0 ? 8'h5F : 8'(8'h30 + $urandom_range(0, 9)));
        end else if (r < 75) begin
            text_q.push_back(8'hC3);
            text_q.push_back($urandom_range(0, 2) == 0 ? ($urandom_range(0, 1) ? 8'hA7 : 8'h87)
                                                      : cont_byte());
        end else if (r < 82) begin
            if ($urandom_range(0, 1)) begin
                text_q.push_back(8'h27);
            end else begin
                text_q.push_back(8'hE2);
                text_q.push_back(8'h80);
                text_q.push_back($urandom_range(0, 1) ? 8'h98 : 8'h99);
            end
        end else if (r < 88) begin
            text_q.push_back(8'($urandom_range(0, 127)));
        end else if (r < 92) begin
            // Four-byte sequence, lead anywhere from F0 to FF.
            text_q.push_back(8'(8'hF0 + $urandom_range(0, 15)));
            repeat (3) text_q.push_back(cont_byte());
        end else if (r < 95) begin
            text_q.push_back($urandom_range(0, 1) ? 8'hE2 : 8'(8'hE0 + $urandom_range(0, 15)));
            text_q.push_back($urandom_range(0, 1) ? 8'h80 : cont_byte());
            text_q.push_back(cont_byte());
        end else if (r < 98) begin
            // A lead byte cut short by a letter; both are dropped.
            text_q.push_back(8'(8'hC0 + $urandom_range(0, 63)));
            text_q.push_back(8'(8'h61 + $urandom_range(0, 25)));
        end else begin
            text_q.push_back(cont_byte());
        end
    endtask

    task automatic add_separator();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            case ($urandom_range(0, 13))
                0:  text_q.push_back(8'h20);
                1:  text_q.push_back(8'h09);
                2:  text_q.push_back(8'h0A);
                3:  text_q.push_back(8'h0D);
                4:  text_q.push_back(8'h2D);
                5:  text_q.push_back(8'h22);
                6:  text_q.push_back(8'h5B);
                7:  text_q.push_back(8'h5D);
                8:  text_q.push_back(8'h2E);
                9:  text_q.push_back(8'h2C);
                10: text_q.push_back(8'h3A);
                11: text_q.push_back(8'h3B);
                12: text_q.push_back(8'h3F);
                default: text_q.push_back(8'h21);
            endcase
        end else if (r < 80) begin
            text_q.push_back(8'hE2);
            text_q.push_back(8'h80);
            case ($urandom_range(0, 3))
                0: text_q.push_back(8'h9C);
                1: text_q.push_back(8'h9D);
                2: text_q.push_back(8'h93);
                default: text_q.push_back(8'hA6);
            endcase
        end else begin
            text_q.push_back(8'($urandom_range(0, 127)));
        end
    endtask

    // A short text of one to three words. It ends on a separator only half
    // the time, and sometimes it is cut so that the last character is
    // incomplete.
    task automatic build_text();
        int words;
        text_q.delete();
        words = $urandom_range(1, 3);
        if ($urandom_range(0, 4) == 0) add_separator();
        for (int w = 0; w < words; w++) begin
            repeat ($urandom_range(1, 5)) add_word_piece();
            if (w < words - 1 || $urandom_range(0, 1)) add_separator();
        end
        if (text_q.size() > 1 && $urandom_range(0, 7) == 0) void'(text_q.pop_back());
    endtask

    // Both handshakes are sampled at the rising edge, before the block's
    // registers move, so the scoreboard sees exactly what the block saw.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_byte(i_data_byte, i_end_of_text);
            if (o_valid && i_ready) sb.check_result(o_total_words, o_repeat_words,
                                                    o_bad_encoding);
        end
    end

    // Receiver: runs of ready, stalls that are mostly short, and one long
    // hold-off when the stimulus asks for it.
    initial begin
        int stall_left;
        int run_left;
        i_ready    = 1'b0;
        stall_left = 0;
        run_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                          : $urandom_range(0, 12);
                    case ($urandom_range(0, 9)) inside
                        0, 1, 2, 3: stall_left = 0;
                        4, 5, 6, 7: stall_left = $urandom_range(1, 3);
                        8:          stall_left = $urandom_range(4, 12);
                        default:    stall_left = $urandom_range(20, 50);
                    endcase
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle = 0;
            else idle++;
        end
        $display("tb_utf8_word_and_repeat_consonant_counter_top: errors");
        $finish;
    end

    initial begin
        int random_sent;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data_byte   = 8'd0;
        i_end_of_text = 1'b0;
        no_gaps       = 1'b0;
        hold_req      = 1'b0;
        random_sent   = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed texts. Mixed case and a C3 letter folded with its ASCII
        // twin, with the final word left without a separator.
        text_q = '{8'h42, 8'h6F, 8'h62, 8'h20, 8'hC3, 8'hA7, 8'h43};
        send_text();
        // An apostrophe inside a word, an ellipsis and the right single quote.
        text_q = '{8'h78, 8'h27, 8'h78, 8'hE2, 8'h80, 8'hA6, 8'h7A, 8'hE2, 8'h80,
                   8'h99, 8'h7A};
        send_text();
        // A cut-short lead, a four-byte character, and a stray continuation
        // byte that is also the final byte.
        text_q = '{8'hC3, 8'h41, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80};
        send_text();
        // Stray byte mid-text, then a word and a three-byte character left
        // incomplete at the end.
        text_q = '{8'h5F, 8'hBF, 8'h39, 8'hE2, 8'h80};
        send_text();
        // An all-ones lead as the whole text.
        text_q = '{8'hFF};
        send_text();

        // Back-pressure: the receiver holds off while the sender keeps
        // offering requests with no gaps, so the block fills and stalls.
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        repeat (PRESSURE_TEXTS) begin
            build_text();
            send_text();
        end
        no_gaps = 1'b0;

        // Let every outstanding result drain before the random part.
        i_valid <= 1'b0;
        while (sb.pending() > 0) @(negedge i_clk);

        while (random_sent < RANDOM_BYTES) begin
            no_gaps = ($urandom_range(0, 5) == 0);
            build_text();
            send_text();
            random_sent += text_q.size();
        end
        no_gaps = 1'b0;

        i_valid <= 1'b0;
        while (sb.pending() > 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_utf8_word_and_repeat_consonant_counter_top: clean");
        end else begin
            $display("tb_utf8_word_and_repeat_consonant_counter_top: errors");
        end
        $finish;
    end

endmodule
